### design/adcf_pkg.sv
// Shared constants for the address/data command framer.
// No dependencies; compiled first.
package adcf_pkg;

  localparam int MAX_FRAME_BYTES = 1024;

  localparam int STYPE_W = 16;
  localparam int COUNT_W = 8;
  localparam int ADDR_W  = 16;
  localparam int DATA_W  = 16;
  localparam int BYTE_W  = 8;

  localparam logic [BYTE_W-1:0] PREAMBLE_BYTE = 8'h55;
  localparam logic [BYTE_W-1:0] TRAILER_BYTE  = 8'hAA;

  // Fixed overhead of a frame: preamble, length, service type, trailer.
  localparam logic [15:0] FRAME_OVERHEAD = 16'd24;
  // Overhead counted in the length word: length, service type, trailer.
  localparam logic [15:0] LEN_OVERHEAD   = 16'd12;

  // Byte positions in the layout of one run: header, one pair, trailer.
  localparam int POS_W = 5;
  localparam logic [POS_W-1:0] POS_HDR_FIRST = 5'd0;
  localparam logic [POS_W-1:0] POS_LEN_LO    = 5'd12;
  localparam logic [POS_W-1:0] POS_LEN_HI    = 5'd13;
  localparam logic [POS_W-1:0] POS_STYPE_LO  = 5'd14;
  localparam logic [POS_W-1:0] POS_STYPE_HI  = 5'd15;
  localparam logic [POS_W-1:0] POS_ADDR_LO   = 5'd16;
  localparam logic [POS_W-1:0] POS_ADDR_HI   = 5'd17;
  localparam logic [POS_W-1:0] POS_DATA_LO   = 5'd18;
  localparam logic [POS_W-1:0] POS_DATA_HI   = 5'd19;
  localparam logic [POS_W-1:0] POS_TRL_FIRST = 5'd20;
  localparam logic [POS_W-1:0] POS_TRL_LAST  = 5'd27;

endpackage

### design/adcf_in_if.sv
// Input channel of the framer: one frame or pair word per handshake.
// Depends on adcf_pkg.
interface adcf_in_if;
  import adcf_pkg::*;

  logic               valid;
  logic               ready;
  logic [STYPE_W-1:0] service_type;
  logic [COUNT_W-1:0] pair_count;
  logic [ADDR_W-1:0]  address;
  logic [DATA_W-1:0]  data;

  modport source (output valid, service_type, pair_count, address, data, input ready);
  modport sink   (input valid, service_type, pair_count, address, data, output ready);
endinterface

### design/adcf_out_if.sv
// Output channel of the framer: one frame byte per handshake.
// Depends on adcf_pkg.
interface adcf_out_if;
  import adcf_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] frame_byte;
  logic              end_of_frame;
  logic              last_of_run;

  modport source (output valid, frame_byte, end_of_frame, last_of_run, input ready);
  modport sink   (input valid, frame_byte, end_of_frame, last_of_run, output ready);
endinterface

### design/addr_data_command_framer_core.sv
// Address/data command framer. Each word on req is turned into a run of frame bytes
// on frame, one byte per cycle through a registered output stage unless frame.ready
// stalls it. A word that opens a frame gives the twelve-byte preamble, the length and
// the service type, then its own pair (20 bytes), or the trailer as well when the frame
// holds one pair (28 bytes), or header and trailer only for a zero count (24 bytes). A
// pair word in mid-frame gives 4 bytes, the closing one 12 with the trailer. The next
// word is taken in the cycle the last byte of a run moves into the output register. An
// opening word whose frame would exceed MAX_FRAME_BYTES is taken and dropped without
// output.
module addr_data_command_framer_core (
  input logic clk,
  input logic rst,
  adcf_in_if.sink    req,
  adcf_out_if.source frame
);
  import adcf_pkg::*;

  // frame state, advanced as words are taken
  logic               in_frame;
  logic [COUNT_W-1:0] pairs_left;

  // run register: the word being serialised
  logic               run_valid;
  logic [POS_W-1:0]   pos;
  logic               run_pair;
  logic               run_trl;
  logic [15:0]        run_len;
  logic [STYPE_W-1:0] run_stype;
  logic [ADDR_W-1:0]  run_addr;
  logic [DATA_W-1:0]  run_data;

  // output register
  logic              out_valid;
  logic [BYTE_W-1:0] out_byte;
  logic              out_eof;
  logic              out_last;

  logic              out_load;
  logic              run_last;
  logic              req_fire;
  logic [15:0]       frame_total;
  logic              oversize;
  logic [POS_W-1:0]  pos_next;
  logic [BYTE_W-1:0] byte_sel;

  assign out_load    = !out_valid || frame.ready;
  assign run_last    = run_trl ? (pos == POS_TRL_LAST) : (pos == POS_DATA_HI);
  assign req.ready   = !run_valid || (out_load && run_last);
  assign req_fire    = req.valid && req.ready;
  assign frame_total = (16'(req.pair_count) << 2) + FRAME_OVERHEAD;
  assign oversize    = frame_total > 16'(MAX_FRAME_BYTES);

  // skip the pair slot when a zero-count frame goes straight to its trailer
  assign pos_next = (pos == POS_STYPE_HI && !run_pair) ? POS_TRL_FIRST : pos + 5'd1;

  always_comb begin
    case (pos)
      POS_LEN_LO:   byte_sel = run_len[7:0];
      POS_LEN_HI:   byte_sel = run_len[15:8];
      POS_STYPE_LO: byte_sel = run_stype[7:0];
      POS_STYPE_HI: byte_sel = run_stype[15:8];
      POS_ADDR_LO:  byte_sel = run_addr[7:0];
      POS_ADDR_HI:  byte_sel = run_addr[15:8];
      POS_DATA_LO:  byte_sel = run_data[7:0];
      POS_DATA_HI:  byte_sel = run_data[15:8];
      default:      byte_sel = (pos < POS_LEN_LO) ? PREAMBLE_BYTE : TRAILER_BYTE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame   <= 1'b0;
      pairs_left <= '0;
      run_valid  <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= run_valid;
        out_byte  <= byte_sel;
        out_eof   <= run_trl && (pos == POS_TRL_LAST);
        out_last  <= run_last;
        // a word taken on the last byte sets up the next run below
        if (run_valid && !req_fire) begin
          pos <= pos_next;
          if (run_last) run_valid <= 1'b0;
        end
      end

      if (req_fire) begin
        run_stype <= req.service_type;
        run_len   <= (16'(req.pair_count) << 2) + LEN_OVERHEAD;
        run_addr  <= req.address;
        run_data  <= req.data;
        if (!in_frame) begin
          if (!oversize) begin
            run_valid <= 1'b1;
            pos       <= POS_HDR_FIRST;
            if (req.pair_count == '0) begin
              run_pair <= 1'b0;
              run_trl  <= 1'b1;
            end else begin
              run_pair   <= 1'b1;
              run_trl    <= (req.pair_count == COUNT_W'(1));
              pairs_left <= req.pair_count - COUNT_W'(1);
              in_frame   <= (req.pair_count != COUNT_W'(1));
            end
          end else begin
            // drop an oversized frame without output
            run_valid <= 1'b0;
          end
        end else begin
          run_valid  <= 1'b1;
          pos        <= POS_ADDR_LO;
          run_pair   <= 1'b1;
          run_trl    <= (pairs_left == COUNT_W'(1));
          pairs_left <= pairs_left - COUNT_W'(1);
          in_frame   <= (pairs_left != COUNT_W'(1));
        end
      end
    end
  end

  assign frame.valid        = out_valid;
  assign frame.frame_byte   = out_byte;
  assign frame.end_of_frame = out_eof;
  assign frame.last_of_run  = out_last;

`ifndef NO_ASSERTIONS
  a_eof_ends_run: assert property (@(posedge clk) disable iff (rst)
    frame.valid && frame.end_of_frame |-> frame.last_of_run)
    else $error("end of frame on a byte that does not end its run");

  a_open_has_pairs: assert property (@(posedge clk) disable iff (rst)
    in_frame |-> pairs_left != '0)
    else $error("frame open with no pairs left");

  a_zero_count_run: assert property (@(posedge clk) disable iff (rst)
    run_valid && !run_pair |-> run_trl && !(pos >= POS_ADDR_LO && pos <= POS_DATA_HI))
    else $error("zero-count run entered the pair slot");

  a_take_on_last: assert property (@(posedge clk) disable iff (rst)
    req_fire && run_valid |-> run_last && out_load)
    else $error("word taken while a run is still in progress");

  a_run_reaches_output: assert property (@(posedge clk) disable iff (rst)
    run_valid && out_load |=> frame.valid)
    else $error("byte of a run did not reach the output register");
`endif

endmodule

### bench/tb.sv
// Self-checking bench for addr_data_command_framer_core: drives request words,
// predicts every frame byte and compares each byte on the output channel.
// Depends on adcf_pkg, adcf_in_if, adcf_out_if and the core.
module tb;
  import adcf_pkg::*;

  localparam int PREAMBLE_LEN   = 12;
  localparam int TRAILER_LEN    = 8;
  localparam int MAX_GAP        = 19;
  localparam int HOLD_OFF       = 300;
  localparam int DRAIN_CYCLES   = 40;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int RANDOM_WORDS   = 130;

  typedef struct packed {
    logic [BYTE_W-1:0] frame_byte;
    logic              end_of_frame;
    logic              last_of_run;
  } frame_byte_t;

  logic clk;
  logic rst;

  adcf_in_if  req_if ();
  adcf_out_if frame_if ();

  addr_data_command_framer_core u_top (
    .clk   (clk),
    .rst   (rst),
    .req   (req_if),
    .frame (frame_if)
  );

  // Predictor state
  logic [COUNT_W-1:0] open_pairs_left;
  logic               frame_open;
  frame_byte_t        run_bytes[$];
  frame_byte_t        pending_bytes[$];

  bit idle_mode;
  int hold_cycles;
  int words_sent;
  int frames_opened;
  int oversized_dropped;
  int bytes_checked;
  int fail_count;
  int quiet_cycles;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic int draw_gap();
    return idle_mode ? $urandom_range(0, MAX_GAP) : 0;
  endfunction

  function automatic void add_byte(input logic [BYTE_W-1:0] b, input logic eof);
    run_bytes.push_back({b, eof, 1'b0});
  endfunction

  function automatic void add_word(input logic [15:0] w);
    add_byte(w[7:0], 1'b0);
    add_byte(w[15:8], 1'b0);
  endfunction

  function automatic void add_trailer();
    for (int i = 0; i < TRAILER_LEN; i++)
      add_byte(TRAILER_BYTE, i == TRAILER_LEN - 1);
  endfunction

  // Work out the bytes that one accepted request word causes.
  function automatic void predict_frame_bytes(input logic [STYPE_W-1:0] st,
                                              input logic [COUNT_W-1:0] cnt,
                                              input logic [ADDR_W-1:0]  ad,
                                              input logic [DATA_W-1:0]  dt);
    frame_byte_t tail;
    logic [15:0] length_word;
    run_bytes.delete();
    if (!frame_open) begin
      // drop an opener whose frame would not fit
      if (int'(FRAME_OVERHEAD) + 4 * int'(cnt) > MAX_FRAME_BYTES) begin
        oversized_dropped++;
        return;
      end
      frames_opened++;
      for (int i = 0; i < PREAMBLE_LEN; i++)
        add_byte(PREAMBLE_BYTE, 1'b0);
      length_word = {6'b0, cnt, 2'b00} + LEN_OVERHEAD;
      add_word(length_word);
      add_word(st);
      if (cnt == '0) begin
        add_trailer();
      end else begin
        add_word(ad);
        add_word(dt);
        open_pairs_left = cnt - 1'b1;
        if (open_pairs_left == '0)
          add_trailer();
        else
          frame_open = 1'b1;
      end
    end else begin
      add_word(ad);
      add_word(dt);
      open_pairs_left = open_pairs_left - 1'b1;
      if (open_pairs_left == '0) begin
        add_trailer();
        frame_open = 1'b0;
      end
    end
    tail = run_bytes.pop_back();
    tail.last_of_run = 1'b1;
    run_bytes.push_back(tail);
    foreach (run_bytes[i])
      pending_bytes.push_back(run_bytes[i]);
  endfunction

  // Predict on every accepted request word, compare on every accepted byte.
  always @(posedge clk) begin : check_frame
    frame_byte_t got;
    frame_byte_t want;
    if (rst === 1'b0) begin
      if (req_if.valid === 1'b1 && req_if.ready === 1'b1)
        predict_frame_bytes(req_if.service_type, req_if.pair_count,
                            req_if.address, req_if.data);
      if (frame_if.valid === 1'b1 && frame_if.ready === 1'b1) begin
        got = {frame_if.frame_byte, frame_if.end_of_frame, frame_if.last_of_run};
        if (pending_bytes.size() == 0) begin
          $error("unexpected frame byte %0h with nothing pending", got.frame_byte);
          fail_count++;
        end else begin
          want = pending_bytes.pop_front();
          bytes_checked++;
          if (got.frame_byte !== want.frame_byte) begin
            $error("frame_byte: expected %0h, got %0h", want.frame_byte, got.frame_byte);
            fail_count++;
          end
          if (got.end_of_frame !== want.end_of_frame) begin
            $error("end_of_frame: expected %0b, got %0b",
                   want.end_of_frame, got.end_of_frame);
            fail_count++;
          end
          if (got.last_of_run !== want.last_of_run) begin
            $error("last_of_run: expected %0b, got %0b",
                   want.last_of_run, got.last_of_run);
            fail_count++;
          end
        end
      end
    end
  end

  // Give up when no word moves on either channel for too long.
  always @(posedge clk) begin
    if (rst === 1'b0) begin
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (frame_if.valid === 1'b1 && frame_if.ready === 1'b1))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Byte receiver: random stalls, plus a long hold-off on request.
  initial begin
    int wait_cycles;
    frame_if.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      if (hold_cycles > 0) begin
        wait_cycles = hold_cycles;
        hold_cycles = 0;
      end else begin
        wait_cycles = draw_gap();
      end
      if (wait_cycles > 0) begin
        frame_if.ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      frame_if.ready <= 1'b1;
      do @(posedge clk); while (frame_if.valid !== 1'b1);
    end
  end

  // Offer one request word and hold it until taken; keep valid high across
  // back-to-back words.
  task automatic send_word(input logic [STYPE_W-1:0] st, input logic [COUNT_W-1:0] cnt,
                           input logic [ADDR_W-1:0] ad, input logic [DATA_W-1:0] dt);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_if.valid        <= 1'b1;
    req_if.service_type <= st;
    req_if.pair_count   <= cnt;
    req_if.address      <= ad;
    req_if.data         <= dt;
    do @(posedge clk); while (req_if.ready !== 1'b1);
    words_sent++;
  endtask

  // Opening word, then one word per remaining pair with junk in the ignored fields.
  task automatic send_frame(input logic [STYPE_W-1:0] st, input logic [COUNT_W-1:0] cnt);
    send_word(st, cnt, ADDR_W'($urandom), DATA_W'($urandom));
    if (int'(FRAME_OVERHEAD) + 4 * int'(cnt) <= MAX_FRAME_BYTES)
      for (int i = 1; i < int'(cnt); i++)
        send_word(STYPE_W'($urandom), COUNT_W'($urandom),
                  ADDR_W'($urandom), DATA_W'($urandom));
  endtask

  task automatic test_zero_count();
    send_word(16'hFFFF, 8'd0, 16'hFFFF, 16'hFFFF);
    send_word(16'h0000, 8'd0, 16'h0000, 16'h0000);
  endtask

  task automatic test_single_pair();
    send_word(16'h0000, 8'd1, 16'hFFFF, 16'h0000);
    send_word(16'hFFFF, 8'd1, 16'h0000, 16'hFFFF);
  endtask

  task automatic test_short_frames();
    send_word(16'h1234, 8'd2, 16'h0000, 16'h0000);
    send_word(16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF);
    send_word(16'hA5C3, 8'd3, 16'h8001, 16'h7FFE);
    send_word(16'h0000, 8'h00, 16'h0000, 16'h0000);
    send_word(16'hFFFF, 8'd250, 16'h5A5A, 16'hA5A5);
  endtask

  task automatic test_oversized_openers();
    send_word(16'hFFFF, 8'd251, 16'hFFFF, 16'hFFFF);
    send_word(16'h0000, 8'd255, 16'h0000, 16'h0000);
    // the block must still be idle here
    send_frame(16'h0F0F, 8'd2);
  endtask

  task automatic test_backpressure();
    idle_mode   = 1'b0;
    hold_cycles = HOLD_OFF;
    repeat (3) send_frame(STYPE_W'($urandom), 8'd6);
    idle_mode   = 1'b1;
  endtask

  task automatic test_random_frames(input int target);
    int first;
    int kind;
    int cnt;
    first = words_sent;
    while (words_sent - first < target) begin
      // alternate stretches with and without idling
      if ($urandom_range(0, 7) == 0)
        idle_mode = ~idle_mode;
      kind = $urandom_range(0, 9);
      if (kind == 0)
        cnt = $urandom_range(251, 255);
      else if (kind == 1)
        cnt = 0;
      else if (kind == 2)
        cnt = $urandom_range(9, 40);
      else
        cnt = $urandom_range(1, 8);
      send_frame(STYPE_W'($urandom), COUNT_W'(cnt));
    end
    idle_mode = 1'b1;
  endtask

  initial begin
    rst                 <= 1'b1;
    req_if.valid        <= 1'b0;
    req_if.service_type <= '0;
    req_if.pair_count   <= '0;
    req_if.address      <= '0;
    req_if.data         <= '0;
    open_pairs_left     = '0;
    frame_open          = 1'b0;
    idle_mode           = 1'b1;
    hold_cycles         = 0;
    words_sent          = 0;
    frames_opened       = 0;
    oversized_dropped   = 0;
    bytes_checked       = 0;
    fail_count          = 0;
    quiet_cycles        = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_zero_count();
    test_single_pair();
    test_short_frames();
    test_oversized_openers();
    test_backpressure();
    test_random_frames(RANDOM_WORDS);

    req_if.valid <= 1'b0;
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d request words: %0d frames opened, %0d oversized openers dropped.",
             words_sent, frames_opened, oversized_dropped);
    $display("Checked %0d frame bytes under random stalls and a long output hold-off.",
             bytes_checked);
    if (fail_count == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
